/* hw/rtl/qhse_pkg.sv */
package qhse_pkg;

  localparam int NCFG      = 6;
  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int T_W       = 17;
  localparam int ACC_W     = 46;
  localparam int PROD_W    = ACC_W + T_W + 1;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_POS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_END_POS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC   = CFG_IDX_W'(5);

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic [T_W-1:0] t;
    acc_t           s;
    acc_t           d;
  } lane_t;

endpackage

/* hw/rtl/qhse_coeff.sv */
module qhse_coeff (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [qhse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qhse_pkg::CFG_W-1:0]          cfg_data,
  output qhse_pkg::acc_t                      coef_s [qhse_pkg::NCOEF],
  output qhse_pkg::acc_t                      coef_d [1:qhse_pkg::NCOEF-1]
);
  import qhse_pkg::*;

  cfg_t cfg_r [NCFG];
  acc_t cs_r  [NCOEF];
  acc_t cs_nxt[NCOEF];
  acc_t cd_r  [1:NCOEF-1];
  acc_t cd_nxt[1:NCOEF-1];
  acc_t p0, v0, a0, p1, v1, a1;

  function automatic acc_t scl(input int k, input acc_t v);
    return ACC_W'(k) * v;
  endfunction

  always_comb begin
    p0 = ACC_W'(cfg_r[REG_START_POS]);
    v0 = ACC_W'(cfg_r[REG_START_VEL]);
    a0 = ACC_W'(cfg_r[REG_START_ACC]);
    p1 = ACC_W'(cfg_r[REG_END_POS]);
    v1 = ACC_W'(cfg_r[REG_END_VEL]);
    a1 = ACC_W'(cfg_r[REG_END_ACC]);
    cs_nxt[0] = scl(2, p0);
    cs_nxt[1] = scl(2, v0);
    cs_nxt[2] = a0;
    cs_nxt[3] = scl(-20, p0) + scl(-12, v0) + scl(-3, a0)
              + scl(20, p1) + scl(-8, v1) + a1;
    cs_nxt[4] = scl(30, p0) + scl(16, v0) + scl(3, a0)
              + scl(-30, p1) + scl(14, v1) + scl(-2, a1);
    cs_nxt[5] = scl(-12, p0) + scl(-6, v0) - a0
              + scl(12, p1) + scl(-6, v1) + a1;
    for (int k = 1; k < NCOEF; k++) begin
      cd_nxt[k] = scl(k, cs_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i++) begin
        cfg_r[i] <= '0;
      end
      for (int k = 0; k < NCOEF; k++) begin
        cs_r[k] <= '0;
      end
      for (int k = 1; k < NCOEF; k++) begin
        cd_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NCFG))) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      cs_r <= cs_nxt;
      cd_r <= cd_nxt;
    end
  end

  assign coef_s = cs_r;
  assign coef_d = cd_r;

endmodule

/* hw/rtl/qhse_cell.sv */
module qhse_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  qhse_pkg::lane_t in_lane,
  input  qhse_pkg::acc_t  coef_s,
  input  qhse_pkg::acc_t  coef_d,
  input  logic            d_en,
  output logic            out_vld,
  output qhse_pkg::lane_t out_lane
);
  import qhse_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] ps, pd;
  logic signed [PROD_W-1:0] rs, rd;
  logic                     vld_r;
  lane_t                    lane_r;
  lane_t                    lane_nxt;
  logic signed [T_W:0]      tm;

  always_comb begin
    tm         = $signed({1'b0, in_lane.t});
    ps         = PROD_W'(in_lane.s) * PROD_W'(tm);
    pd         = PROD_W'(in_lane.d) * PROD_W'(tm);
    rs         = ps + HALF;
    rd         = pd + HALF;
    lane_nxt.t = in_lane.t;
    lane_nxt.s = coef_s + acc_t'(rs[ACC_W+FRAC_W-1:FRAC_W]);
    lane_nxt.d = d_en ? (coef_d + acc_t'(rd[ACC_W+FRAC_W-1:FRAC_W])) : in_lane.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    lane_r <= lane_nxt;
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;

endmodule

/* hw/rtl/quintic_hermite_segment_eval_top.sv */
// Quintic Hermite segment evaluator, one axis.
// Pipeline: start is loaded into the input register, then passes five Horner cells
// of one multiply-add each and the output register, which drives out_valid.
// Throughput: one transfer per cycle; busy is always low and no result is held.
// Reset: synchronous active-low; valid flags, configuration and coefficients clear
// to zero; a configuration write reaches the coefficients via the config register.
module quintic_hermite_segment_eval_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [qhse_pkg::T_W-1:0]          in_time_frac,
  input  logic                              cfg_wr_en,
  input  logic [qhse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qhse_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  output logic signed [qhse_pkg::OUT_W-1:0] out_position,
  output logic signed [qhse_pkg::OUT_W-1:0] out_velocity,
  output logic                              out_clipped
);
  import qhse_pkg::*;

  localparam int NCELL = NCOEF - 1;

  acc_t  coef_s [NCOEF];
  acc_t  coef_d [1:NCOEF-1];
  logic  vld    [NCELL+1];
  lane_t lane   [NCELL+1];

  logic  vld0_r;
  lane_t lane0_r;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_position_r, out_position_nxt;
  logic signed [OUT_W-1:0] out_velocity_r, out_velocity_nxt;
  logic                    out_clipped_r, out_clipped_nxt;

  acc_t qs, qd;
  logic ovf_s, ovf_d;

  qhse_coeff u_coeff (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_s    (coef_s),
    .coef_d    (coef_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start;
    end
    lane0_r.t <= in_time_frac;
    lane0_r.s <= coef_s[NCOEF-1];
    lane0_r.d <= coef_d[NCOEF-1];
  end

  assign vld[0]  = vld0_r;
  assign lane[0] = lane0_r;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    localparam int K = NCELL - 1 - j;
    if (K > 0) begin : g_full
      qhse_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld[j]),
        .in_lane  (lane[j]),
        .coef_s   (coef_s[K]),
        .coef_d   (coef_d[K]),
        .d_en     (1'b1),
        .out_vld  (vld[j+1]),
        .out_lane (lane[j+1])
      );
    end else begin : g_last
      qhse_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld[j]),
        .in_lane  (lane[j]),
        .coef_s   (coef_s[0]),
        .coef_d   ('0),
        .d_en     (1'b0),
        .out_vld  (vld[j+1]),
        .out_lane (lane[j+1])
      );
    end
  end

  always_comb begin
    qs    = (lane[NCELL].s + ACC_W'(1)) >>> 1;
    qd    = (lane[NCELL].d + ACC_W'(1)) >>> 1;
    ovf_s = (qs[ACC_W-1:OUT_W-1] != '0) && (qs[ACC_W-1:OUT_W-1] != '1);
    ovf_d = (qd[ACC_W-1:OUT_W-1] != '0) && (qd[ACC_W-1:OUT_W-1] != '1);
    if (ovf_s) begin
      out_position_nxt = qs[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      out_position_nxt = qs[OUT_W-1:0];
    end
    if (ovf_d) begin
      out_velocity_nxt = qd[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      out_velocity_nxt = qd[OUT_W-1:0];
    end
    out_clipped_nxt = ovf_s || ovf_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld[NCELL];
    end
    out_position_r <= out_position_nxt;
    out_velocity_r <= out_velocity_nxt;
    out_clipped_r  <= out_clipped_nxt;
  end

  assign busy         = 1'b0;
  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_velocity = out_velocity_r;
  assign out_clipped  = out_clipped_r;

endmodule
